/* hdl/utu_pkg.sv */
// shared types and constants for the utf-8 to utf-16 transcoder
// used by utu_front, utu_fifo, utu_back and the top level
package utu_pkg;

    localparam int CountBits = 16;
    localparam int CapBits   = 16;
    localparam int CmpBits   = ((CountBits > CapBits) ? CountBits : CapBits) + 2;
    localparam int FifoDepth = 4;
    localparam int PtrBits   = $clog2(FifoDepth);
    localparam int CntBits   = $clog2(FifoDepth + 1);

    localparam logic [20:0] SurrLo   = 21'h00d800;
    localparam logic [20:0] SurrHi   = 21'h00e000;
    localparam logic [20:0] CodeMax  = 21'h10ffff;
    localparam logic [20:0] SuppBase = 21'h010000;
    localparam logic [15:0] HighBase = 16'hd800;
    localparam logic [15:0] LowBase  = 16'hdc00;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ILL  = 2'd1,
        STATUS_ENC  = 2'd2,
        STATUS_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
        logic        pair;
        logic        is_end;
        status_t     status;
    } entry_t;

endpackage

/* hdl/utu_front.sv */
// front end: decodes utf-8 bytes, tracks string state and queues result entries
// depends on utu_pkg
module utu_front
    import utu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                cfg_valid,
    input  logic [CapBits-1:0]  cfg_data,
    input  logic                q_full,
    output logic                q_push,
    output entry_t              q_entry
);

    logic [CapBits-1:0]   cap_reg;
    logic [20:0]          partial_reg, partial_next;
    logic [1:0]           pend_reg, pend_next;
    logic [CountBits-1:0] uw_reg, uw_next;
    logic                 skip_reg, skip_next;

    logic                 accept;
    logic [7:0]           b;
    logic [20:0]          np;
    logic [20:0]          key;
    logic [19:0]          koff;
    logic                 enc;
    logic                 do_end;
    status_t              end_status;
    logic                 end_skip;
    logic [CmpBits-1:0]   uw_ext, cap_ext, uw_p1, uw_p2, cnt_max;
    logic                 cap_on, full1, full2;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign np       = {partial_reg[14:0], b[5:0]};
    assign uw_ext   = CmpBits'(uw_reg);
    assign cap_ext  = CmpBits'(cap_reg);
    assign uw_p1    = uw_ext + CmpBits'(1);
    assign uw_p2    = uw_ext + CmpBits'(2);
    assign cnt_max  = CmpBits'({CountBits{1'b1}});
    assign cap_on   = (cap_reg != '0);
    assign full1    = cap_on && (uw_p1 >= cap_ext);
    assign full2    = cap_on && (uw_p2 >= cap_ext);

    always_comb begin
        partial_next = partial_reg;
        pend_next    = pend_reg;
        uw_next      = uw_reg;
        skip_next    = skip_reg;
        q_push       = 1'b0;
        q_entry      = '0;
        enc          = 1'b0;
        key          = '0;
        koff         = '0;
        do_end       = 1'b0;
        end_status   = STATUS_OK;
        end_skip     = 1'b0;
        if (accept) begin
            if (skip_reg) begin
                if (b == 8'h00) begin
                    skip_next = 1'b0;
                end
            end else if (pend_reg == 2'd0) begin
                if (b == 8'h00) begin
                    do_end = 1'b1;
                end else if (!b[7]) begin
                    enc = 1'b1;
                    key = 21'(b);
                end else if (b[7:5] == 3'b110) begin
                    partial_next = 21'(b[4:0]);
                    pend_next    = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    partial_next = 21'(b[3:0]);
                    pend_next    = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    partial_next = 21'(b[2:0]);
                    pend_next    = 2'd3;
                end else begin
                    do_end     = 1'b1;
                    end_status = STATUS_ILL;
                    end_skip   = 1'b1;
                end
            end else begin
                if (b == 8'h00) begin
                    do_end     = 1'b1;
                    end_status = STATUS_ILL;
                end else if (b[7:6] != 2'b10) begin
                    do_end     = 1'b1;
                    end_status = STATUS_ILL;
                    end_skip   = 1'b1;
                end else begin
                    partial_next = np;
                    pend_next    = pend_reg - 2'd1;
                    if (pend_reg == 2'd1) begin
                        enc          = 1'b1;
                        key          = np;
                        partial_next = '0;
                    end
                end
            end

            if (enc) begin
                koff = 20'(key - SuppBase);
                if (((key >= SurrLo) && (key < SurrHi)) || (key > CodeMax)) begin
                    do_end     = 1'b1;
                    end_status = STATUS_ENC;
                    end_skip   = 1'b1;
                end else if (full1) begin
                    do_end     = 1'b1;
                    end_status = STATUS_FULL;
                    end_skip   = 1'b1;
                end else if (key < SuppBase) begin
                    q_push          = 1'b1;
                    q_entry.unit_lo = key[15:0];
                    uw_next = (uw_p1 > cnt_max) ? uw_reg : uw_p1[CountBits-1:0];
                end else if (full2) begin
                    do_end     = 1'b1;
                    end_status = STATUS_FULL;
                    end_skip   = 1'b1;
                end else begin
                    q_push          = 1'b1;
                    q_entry.pair    = 1'b1;
                    q_entry.unit_hi = HighBase | 16'(koff[19:10]);
                    q_entry.unit_lo = LowBase | 16'(koff[9:0]);
                    uw_next = (uw_p2 > cnt_max) ? {CountBits{1'b1}} : uw_p2[CountBits-1:0];
                end
            end

            if (do_end) begin
                q_push         = 1'b1;
                q_entry        = '0;
                q_entry.is_end = 1'b1;
                q_entry.status = end_status;
                partial_next   = '0;
                pend_next      = 2'd0;
                uw_next        = '0;
                skip_next      = end_skip;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= '0;
            partial_reg <= '0;
            pend_reg    <= 2'd0;
            uw_reg      <= '0;
            skip_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            partial_reg <= partial_next;
            pend_reg    <= pend_next;
            uw_reg      <= uw_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

/* hdl/utu_fifo.sv */
// short queue of result entries between front and back end
// depends on utu_pkg
module utu_fifo
    import utu_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t wr_entry,
    input  logic   pop,
    output entry_t rd_entry,
    output logic   empty,
    output logic   full
);

    entry_t               mem [FifoDepth];
    logic [PtrBits-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntBits-1:0]   count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CntBits'(FifoDepth));
    assign rd_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrBits'(FifoDepth - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrBits'(FifoDepth - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/utu_back.sv */
// back end: turns queued entries into output words, splitting surrogate pairs
// depends on utu_pkg
module utu_back
    import utu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  entry_t      q_entry,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    logic [15:0] data_reg, data_next;
    logic [2:0]  user_reg, user_next;
    logic        last_reg, last_next;
    logic        phase_reg, phase_next;
    logic        load;

    assign load     = (!valid_reg || m_tready) && !q_empty;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        phase_next = phase_reg;
        q_pop      = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            user_next  = {q_entry.status, q_entry.is_end};
            if (q_entry.pair && !phase_reg) begin
                data_next  = q_entry.unit_hi;
                last_next  = 1'b0;
                phase_next = 1'b1;
            end else begin
                data_next  = q_entry.unit_lo;
                last_next  = 1'b1;
                phase_next = 1'b0;
                q_pop      = 1'b1;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

endmodule

/* hdl/utf8_to_utf16_transcoder.sv */
// top level of the utf-8 to utf-16 transcoder
// instantiates utu_front, utu_fifo and utu_back; depends on utu_pkg
//
// input stream s_*: one utf-8 byte per word in s_tdata; 0x00 ends a string
// output stream m_*: one utf-16 code unit per word; tuser flags end-of-string
//   words and their status, tlast marks the final word caused by one byte
// config channel cfg_*: output capacity in code units including the
//   terminator, 0 for unlimited; always ready, write only while idle
// a byte is accepted every cycle while the four-entry result queue has room
// the first word of a byte is registered by the back end once decode has
//   written its entry into the queue at the accepting edge
// a byte yields zero, one or two words; the two words of a supplementary
//   character are its high and then its low surrogate, from one queue entry
// when the receiver stalls the queue fills and s_tready drops
// reset clears the string state, the capacity, the queue and m_tvalid
module utf8_to_utf16_transcoder
    import utu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // byte_in
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // code_unit
    output logic [2:0]         m_tuser,   // status[1:0], is_end
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CapBits-1:0] cfg_data   // out_capacity
);

    entry_t push_entry, pop_entry;
    logic   q_push, q_pop, q_empty, q_full;

    assign cfg_ready = 1'b1;

    utu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    utu_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (push_entry),
        .pop      (q_pop),
        .rd_entry (pop_entry),
        .empty    (q_empty),
        .full     (q_full)
    );

    utu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_entry  (pop_entry),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* hdl/utu_checker.sv */
// port-level checks for the utf-8 to utf-16 transcoder, bound to the top level
// watches the output stream only; no package needed
module utu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // output idle right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // end word carries zero unit and closes the byte
    a_end_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'h0000) && m_tlast)
        else $error("malformed end word");

    // unit word has zero status
    a_unit_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tuser[2:1] == 2'b00))
        else $error("status on unit word");

    // only a high surrogate is followed by more words of the same byte
    a_not_last_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[15:10] == 6'b110110) && !m_tuser[0])
        else $error("non-final word is not a high surrogate");

    // low surrogate follows at once
    a_low_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            m_tvalid && m_tlast && (m_tdata[15:10] == 6'b110111))
        else $error("low surrogate missing");

endmodule

bind utf8_to_utf16_transcoder utu_checker u_utu_checker (.*);
